>>> design/imu_pkg.sv
package imu_pkg;

   localparam int ROWS_DEF = 32;
   localparam int COLS_DEF = 32;

   localparam int CSR_ADDR_W = 3;

   // Register index, taken from bit 2 of the byte address.
   localparam logic CSR_THRESH_4 = 1'b0;
   localparam logic CSR_THRESH_8 = 1'b1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [4:0]  row;
      logic [4:0]  col;
      logic        spin_up;
      logic [15:0] rand_word;
   } req_type;

   typedef struct packed {
      logic signed [12:0] energy;
      logic signed [11:0] magnetization;
      logic               flipped;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic rd_centre;
      logic rd_down;
      logic exec;
   } imu_cmd_type;

endpackage

>>> design/imu_ctrl.sv
module imu_ctrl
   import imu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output imu_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_RD_CENTRE = 4'b0010,
      ST_RD_DOWN   = 4'b0100,
      ST_EXEC      = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      exec_go;

   // The final step waits only while an earlier word is still unclaimed.
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RD_CENTRE;
         end
         ST_RD_CENTRE: state_in = ST_RD_DOWN;
         ST_RD_DOWN:   state_in = ST_EXEC;
         ST_EXEC: begin
            if (exec_go) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (exec_go) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_comb begin
      cmd.load_item = req_valid && (state_ff == ST_IDLE);
      cmd.rd_centre = (state_ff == ST_RD_CENTRE);
      cmd.rd_down   = (state_ff == ST_RD_DOWN);
      cmd.exec      = exec_go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/imu_dpath.sv
module imu_dpath
   import imu_pkg::*;
#(
   parameter int ROWS = ROWS_DEF,
   parameter int COLS = COLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  imu_cmd_type cmd,
   input  req_type     req_word,
   input  logic [15:0] thresh_4,
   input  logic [15:0] thresh_8,
   output rsp_type     rsp_word
);

   localparam int RW     = $clog2(ROWS);
   localparam int CW     = $clog2(COLS);
   localparam int CELL_N = ROWS * COLS;
   localparam int EW     = $clog2(CELL_N) + 3;
   localparam int MW     = $clog2(CELL_N) + 2;

   // Lattice held one row to a memory word; a row never written reads as all up.
   logic [COLS-1:0] lat_mem [ROWS];
   logic [ROWS-1:0] row_ok_ff;

   req_type         item_ff;
   logic [COLS-1:0] q0_ff, q1_ff, up_row_ff;
   logic            ok0_ff, ok1_ff;
   logic signed [EW-1:0] energy_ff, energy_in;
   logic signed [MW-1:0] magnet_ff, magnet_in;
   rsp_type         rsp_ff;

   logic [RW-1:0]   r_idx, r_up, r_dn, rd1_addr;
   logic [CW-1:0]   c_idx, c_lf, c_rt;
   logic            in_range;
   logic [COLS-1:0] centre_row, down_row, new_row;
   logic            s;
   logic [2:0]      k, a;
   logic            take, flip;
   logic signed [5:0]  de;
   logic signed [31:0] e_wide, m_wide;

   assign in_range = (32'(item_ff.row) < ROWS) && (32'(item_ff.col) < COLS);
   assign r_idx    = RW'(item_ff.row);
   assign c_idx    = CW'(item_ff.col);
   assign r_up     = (r_idx == '0) ? RW'(ROWS - 1) : r_idx - RW'(1);
   assign r_dn     = (r_idx == RW'(ROWS - 1)) ? '0 : r_idx + RW'(1);
   assign c_lf     = (c_idx == '0) ? CW'(COLS - 1) : c_idx - CW'(1);
   assign c_rt     = (c_idx == CW'(COLS - 1)) ? '0 : c_idx + CW'(1);
   assign rd1_addr = cmd.rd_centre ? r_up : r_dn;

   always_ff @(posedge clock) begin
      if (cmd.load_item) item_ff <= req_word;
      if (cmd.rd_centre) begin
         q0_ff  <= lat_mem[r_idx];
         ok0_ff <= row_ok_ff[r_idx];
      end
      if (cmd.rd_centre || cmd.rd_down) begin
         q1_ff  <= lat_mem[rd1_addr];
         ok1_ff <= row_ok_ff[rd1_addr];
      end
      // The up row arrives while the down row is being fetched.
      if (cmd.rd_down) up_row_ff <= ok1_ff ? q1_ff : '1;
      if (cmd.exec && flip) lat_mem[r_idx] <= new_row;
      if (cmd.exec) rsp_ff <= '{energy: e_wide[12:0], magnetization: m_wide[11:0],
                                flipped: flip};
   end

   assign centre_row = ok0_ff ? q0_ff : '1;
   assign down_row   = ok1_ff ? q1_ff : '1;
   assign s          = centre_row[c_idx];
   assign k          = 3'(up_row_ff[c_idx]) + 3'(down_row[c_idx])
                     + 3'(centre_row[c_lf]) + 3'(centre_row[c_rt]);
   // Number of neighbours aligned with the centre spin; dE = 4*a - 8.
   assign a          = s ? k : 3'd4 - k;
   assign de         = $signed({1'b0, a, 2'b00}) - 6'sd8;
   assign take       = (a <= 3'd2)
                     || ((a == 3'd3) && (item_ff.rand_word <= thresh_4))
                     || ((a == 3'd4) && (item_ff.rand_word <= thresh_8));
   assign flip       = in_range && ((item_ff.cmd == CMD_LOAD) ?
                                    (s != item_ff.spin_up) : take);
   assign new_row    = centre_row ^ (COLS'(1) << c_idx);

   assign energy_in = flip ? energy_ff + EW'(de) : energy_ff;
   assign magnet_in = flip ? (s ? magnet_ff - MW'(2) : magnet_ff + MW'(2)) : magnet_ff;
   assign e_wide    = 32'(energy_in);
   assign m_wide    = 32'(magnet_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ok_ff <= '0;
         energy_ff <= -EW'(2 * CELL_N);
         magnet_ff <= MW'(CELL_N);
      end else if (cmd.exec) begin
         if (flip) row_ok_ff[r_idx] <= 1'b1;
         energy_ff <= energy_in;
         magnet_ff <= magnet_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

>>> design/ising_metropolis_update_unit.sv
// Metropolis update unit for a periodic 2D Ising lattice of ROWS x COLS spins, all +1 after
// reset, with running energy and magnetization. Each request word either loads one spin or
// attempts one Metropolis flip, and produces one response word with both totals and a flag
// saying whether the spin changed. After its acceptance a request passes through ST_RD_CENTRE
// and ST_RD_DOWN, where the centre, up and down rows are read from a two-port row memory that
// holds the lattice, then ST_EXEC, which waits while an earlier word is unclaimed, decides and
// writes back. A new request is accepted in the cycle after the previous one leaves for the
// response register, so only one word is in the unit at a time. Flips
// raising the energy by 4 or by 8 are taken when rand_word is at most the threshold register
// for that rise (byte offsets 0 and 4). No clearing pass follows reset.
module ising_metropolis_update_unit
   import imu_pkg::*;
#(
   parameter int ROWS = ROWS_DEF,
   parameter int COLS = COLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_word,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam logic CELL_ODD = 1'((ROWS * COLS) % 2);

   imu_cmd_type cmd;
   logic [15:0] thresh_4_ff, thresh_8_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_4_ff <= '0;
         thresh_8_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            CSR_THRESH_4: thresh_4_ff <= csr_pwdata[15:0];
            CSR_THRESH_8: thresh_8_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_THRESH_4: csr_prdata = {16'b0, thresh_4_ff};
         CSR_THRESH_8: csr_prdata = {16'b0, thresh_8_ff};
         default:      csr_prdata = '0;
      endcase
   end

   imu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   imu_dpath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .thresh_4 (thresh_4_ff),
      .thresh_8 (thresh_8_ff),
      .rsp_word (rsp_word)
   );

   // Only one request is in the datapath at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // With the response side free, each new response word goes back to an accepted request.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 4))
      else $error("response word without a matching request");

   // Energy is always even and magnetization has the parity of the cell count.
   a_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_word.energy[0] && (rsp_word.magnetization[0] == CELL_ODD)))
      else $error("running totals lost their parity");

endmodule
